FILE: hdl/sorted_key_list_macros.svh
// Assertion macros shared by the sorted_key_list checker.
// No dependencies; include by bare file name.
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SKL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_list: implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define SKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_list: next-cycle check failed");

`endif

FILE: hdl/skl_pkg.sv
// Shared types and constants for the sorted key list.
// No dependencies; used by every module of the block.
package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_POP_MIN = 3'd1,
    OP_POP_MAX = 3'd2,
    OP_TAKE    = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [KEY_W-1:0]  key;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  value;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } out_word_t;

  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // apply the operation and fill the output register
  } skl_cmd_t;

endpackage

FILE: hdl/skl_ctrl.sv
// Controller for the sorted key list: handshakes and sequencing.
// Depends on skl_pkg.
module skl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output skl_pkg::skl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load      = in_valid && (state_r == S_IDLE);
    cmd.exec      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // wait for the output register to drain before committing
        if (cmd.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/skl_datapath.sv
// Datapath for the sorted key list: input register, key array with parallel
// compare and shift, key count and output register. Depends on skl_pkg.
module skl_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  skl_pkg::skl_cmd_t  cmd,
  input  skl_pkg::in_word_t  in_data,
  output skl_pkg::out_word_t out_data
);

  skl_pkg::in_word_t              in_r;
  skl_pkg::out_word_t             out_r;
  logic [skl_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [skl_pkg::KEY_W-1:0] store_r   [skl_pkg::CAPACITY];
  logic signed [skl_pkg::KEY_W-1:0] store_nxt [skl_pkg::CAPACITY];
  logic [skl_pkg::CAPACITY-1:0]   lt;

  logic                           full, empty, pos_ok;
  logic                           do_ins, do_rm;
  logic [skl_pkg::IDX_W-1:0]      sel_idx;
  logic [skl_pkg::CNT_W-1:0]      cnt_m1;
  logic [skl_pkg::POS_W-1:0]      pos_m1;
  logic signed [skl_pkg::KEY_W-1:0] sel_key, val;
  skl_pkg::status_t               st;

  assign full    = (cnt_r == skl_pkg::CNT_W'(skl_pkg::CAPACITY));
  assign empty   = (cnt_r == '0);
  assign pos_ok  = (in_r.position != '0) && (int'(in_r.position) <= int'(cnt_r));
  assign cnt_m1  = cnt_r - skl_pkg::CNT_W'(1);
  assign pos_m1  = in_r.position - skl_pkg::POS_W'(1);
  assign sel_key = store_r[sel_idx];

  always_comb begin
    case (in_r.operation)
      skl_pkg::OP_POP_MIN: sel_idx = '0;
      skl_pkg::OP_POP_MAX: sel_idx = cnt_m1[skl_pkg::IDX_W-1:0];
      default:             sel_idx = pos_m1[skl_pkg::IDX_W-1:0];
    endcase
  end

  always_comb begin
    st     = skl_pkg::ST_OK;
    val    = '0;
    do_ins = 1'b0;
    do_rm  = 1'b0;
    case (in_r.operation) inside
      skl_pkg::OP_INSERT: begin
        if (full) st = skl_pkg::ST_FULL;
        else      do_ins = 1'b1;
      end
      skl_pkg::OP_POP_MIN, skl_pkg::OP_POP_MAX: begin
        if (empty) begin
          st = skl_pkg::ST_EMPTY;
        end else begin
          val   = sel_key;
          do_rm = 1'b1;
        end
      end
      skl_pkg::OP_TAKE, skl_pkg::OP_READ: begin
        if (empty) begin
          st = skl_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          st = skl_pkg::ST_RANGE;
        end else begin
          val   = sel_key;
          do_rm = (in_r.operation == skl_pkg::OP_TAKE);
        end
      end
      default: ;  // unused codes: no operation
    endcase
  end

  // Per-entry next value; lt is a thermometer code over the sorted keys.
  for (genvar i = 0; i < skl_pkg::CAPACITY; i++) begin : g_entry
    assign lt[i] = (skl_pkg::CNT_W'(i) < cnt_r) && (store_r[i] < in_r.key);

    always_comb begin
      store_nxt[i] = store_r[i];
      if (do_ins && !lt[i]) begin
        if (i == 0) store_nxt[i] = in_r.key;
        else if (lt[(i == 0) ? 0 : i - 1]) store_nxt[i] = in_r.key;
        else store_nxt[i] = store_r[(i == 0) ? 0 : i - 1];
      end else if (do_rm && (skl_pkg::IDX_W'(i) >= sel_idx)) begin
        if (i < skl_pkg::CAPACITY - 1)
          store_nxt[i] = store_r[(i < skl_pkg::CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins)     cnt_nxt = cnt_r + skl_pkg::CNT_W'(1);
    else if (do_rm) cnt_nxt = cnt_m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.exec) begin
      for (int j = 0; j < skl_pkg::CAPACITY; j++) store_r[j] <= store_nxt[j];
      out_r.value  <= val;
      out_r.status <= st;
      out_r.count  <= skl_pkg::COUNT_W'(cnt_nxt);
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/sorted_key_list.sv
// Sorted key list: up to CAPACITY signed keys kept in ascending order.
// Input channel (in_valid/in_ready/in_data) carries one word per operation:
// insert a key, remove the smallest or largest key, remove the key at a
// one-based position, or read the key at a one-based position.
// Output channel (out_valid/out_ready/out_data) returns one word per input
// word: the affected key, a status (ok, full, empty, bad position) and the
// count after the operation. An operation that fails leaves the list as is.
// The input register takes the word; once the output register is free or
// being drained, the key array compares and shifts all entries and the
// result word is written to the output register.
// Only one word is in flight; in_ready is low while it is being applied.
// If the receiver stalls, the result holds in the output register and the
// next input word is taken but not applied until the result is taken.
// Reset (rst_n, synchronous, active low) empties the list at once; the key
// array itself is not cleared, as entries past the count are never read.
module sorted_key_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  skl_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output skl_pkg::out_word_t out_data
);

  skl_pkg::skl_cmd_t cmd;

  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  skl_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: hdl/skl_checker.sv
// Port-level checks for sorted_key_list, bound to the top level.
// Depends on skl_pkg and sorted_key_list_macros.svh.
`include "sorted_key_list_macros.svh"

module skl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input skl_pkg::out_word_t out_data
);

  `SKL_ASSERT_IMPLY(a_count_max, clk, rst_n, out_valid,
                    int'(out_data.count) <= skl_pkg::CAPACITY)

  `SKL_ASSERT_IMPLY(a_err_zero, clk, rst_n,
                    out_valid && (out_data.status != skl_pkg::ST_OK),
                    out_data.value == '0)

  `SKL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  `SKL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind sorted_key_list skl_checker u_skl_checker (.*);

FILE: verif/tb_sorted_key_list.sv
// Self-checking bench for sorted_key_list: random and directed list operations
// with a sorted-list predictor and a queue of predicted reply words.
// Depends on skl_pkg and the sorted_key_list RTL.
module tb_sorted_key_list;
  import skl_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  sorted_key_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_word_t  op_words[$];
  out_word_t predicted_replies[$];
  int        errors = 0;
  int        words_taken = 0;
  int        replies_seen = 0;
  int        planned_len = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  logic      hold_off = 1'b0;

  // Predictor state: ascending keys, only entries below list_len are valid.
  logic signed [KEY_W-1:0] list_keys [CAPACITY];
  int                      list_len = 0;

  function automatic logic signed [KEY_W-1:0] take_key(int idx);
    logic signed [KEY_W-1:0] k;
    k = list_keys[idx];
    for (int i = idx; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
    list_len--;
    return k;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int        at;
    r = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // New key goes ahead of any equal keys.
          at = 0;
          while (at < list_len && list_keys[at] < w.key) at++;
          for (int i = list_len; i > at; i--) list_keys[i] = list_keys[i - 1];
          list_keys[at] = w.key;
          list_len++;
        end
      end
      OP_POP_MIN, OP_POP_MAX, OP_TAKE, OP_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (w.operation == OP_POP_MIN) begin
          r.value = take_key(0);
        end else if (w.operation == OP_POP_MAX) begin
          r.value = take_key(list_len - 1);
        end else if (w.position == 0 || w.position > list_len) begin
          r.status = ST_RANGE;
        end else if (w.operation == OP_TAKE) begin
          r.value = take_key(w.position - 1);
        end else begin
          r.value = list_keys[w.position - 1];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // Queue a word and track the list length so positions can be aimed.
  task automatic queue_word(op_t op, logic signed [KEY_W-1:0] k, int pos);
    in_word_t w;
    w.operation = op;
    w.key = k;
    w.position = POS_W'(pos);
    op_words.push_back(w);
    case (op)
      OP_INSERT:  if (planned_len < CAPACITY) planned_len++;
      OP_POP_MIN, OP_POP_MAX: if (planned_len > 0) planned_len--;
      OP_TAKE:    if (pos >= 1 && pos <= planned_len) planned_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // narrow range to force duplicates
      k = $urandom_range(0, 8);
      k = k - 4;
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0: k = 32'sh7fffffff;
        1: k = 32'sh80000000;
        2: k = '0;
        default: k = -1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  function automatic int rand_pos(int len);
    if (len > 0 && $urandom_range(0, 99) < 80) return $urandom_range(1, len);
    return $urandom_range(0, 16);
  endfunction

  // Mostly short gaps, a few long, and whole stretches with none.
  function automatic int pick_gap(int seq);
    int r;
    if ((seq / 128) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on reply %0d, %s: got %0d, expected %0d",
             replies_seen, what, got, want);
    errors++;
  endtask

  // Driver: hold each word until taken, then advance after a random gap.
  always @(posedge clk) begin : drive_words
    bit take_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      take_next = !in_valid;
      if (in_valid && in_ready) begin
        predicted_replies.push_back(apply_word(in_data));
        words_taken++;
        take_next = 1'b1;
      end
      if (take_next) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_words.size() > 0) begin
          in_data <= op_words.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(words_taken);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply word with the oldest prediction.
  always @(posedge clk) begin : check_replies
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected word, value", out_data.value, 0);
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.value !== want.value)
            report_mismatch("value", out_data.value, want.value);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.count !== want.count)
            report_mismatch("count", out_data.count, want.count);
        end
        replies_seen++;
        recv_gap = pick_gap(replies_seen + 64);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver stall while the sender keeps offering words.
  initial begin
    while (words_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int mode;
    int seg_len;
    int ins_pct;
    op_t op;

    // Empty store: every remove and read must report empty.
    queue_word(OP_POP_MIN, 0, 0);
    queue_word(OP_POP_MAX, 0, 0);
    queue_word(OP_TAKE, 0, 3);
    queue_word(OP_READ, 0, 0);
    queue_word(OP_READ, 0, 16);
    // Extreme keys and a duplicate.
    queue_word(OP_INSERT, 32'sh7fffffff, 0);
    queue_word(OP_INSERT, 32'sh80000000, 31);
    queue_word(OP_INSERT, 0, 0);
    queue_word(OP_INSERT, -1, 0);
    queue_word(OP_INSERT, 0, 0);
    queue_word(OP_INSERT, 7, 0);
    // Position zero and past the count; both ends and the middle.
    queue_word(OP_READ, 0, 0);
    queue_word(OP_READ, 0, 1);
    queue_word(OP_READ, 0, 6);
    queue_word(OP_READ, 0, 7);
    queue_word(OP_TAKE, 0, 0);
    queue_word(OP_TAKE, 0, 16);
    queue_word(OP_TAKE, 0, 3);
    queue_word(OP_POP_MIN, 0, 0);
    queue_word(OP_POP_MAX, 0, 0);
    queue_word(OP_INSERT, 0, 0);
    queue_word(OP_READ, 0, 2);

    // Fill to capacity, then overflow.
    while (planned_len < CAPACITY) queue_word(OP_INSERT, rand_key(), 0);
    queue_word(OP_INSERT, rand_key(), 0);
    queue_word(OP_INSERT, 32'sh80000000, 0);
    queue_word(OP_READ, 0, 16);

    // Segments that lean toward filling, draining, or a mix.
    while (op_words.size() < 1550) begin
      mode = $urandom_range(0, 2);
      seg_len = $urandom_range(8, 48);
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          queue_word(OP_INSERT, rand_key(), $urandom_range(0, 31));
        end else begin
          case ($urandom_range(0, 3))
            0: op = OP_POP_MIN;
            1: op = OP_POP_MAX;
            2: op = OP_TAKE;
            default: op = OP_READ;
          endcase
          queue_word(op, rand_key(), rand_pos(planned_len));
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_words.size() != 0 || in_valid) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
